// ===== design/tgbc_pkg.sv =====
`timescale 1ns / 1ps
package tgbc_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  // Tile bounds: |origin| < 2^31, up to 128 strides of < 2^31 each
  localparam int COORD_W = 42;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_TILE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_TILE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COLUMNS     = 3'd4;
  localparam logic [2:0] REG_ROWS        = 3'd5;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [30:0]        tile_width;
    logic [30:0]        tile_height;
    logic [6:0]         columns;
    logic [6:0]         rows;
  } cfg_t;

  typedef struct packed {
    logic load;    // input transfer, latch fields
    logic wr_rd;   // read row word for tile write
    logic wr_wb;   // write back modified row word
    logic q_init;  // start query sweep
    logic q_step;  // one sweep step
    logic q_fin;   // reduce to hit flag
  } cmd_t;

endpackage

// ===== design/tgbc_regs.sv =====
`timescale 1ns / 1ps
module tgbc_regs
  import tgbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.tile_width  <= 31'd65536;
      cfg.tile_height <= 31'd65536;
      cfg.columns     <= 7'd64;
      cfg.rows        <= 7'd64;
    end else if (wr) begin
      case (idx)
        REG_ORIGIN_X:    cfg.origin_x    <= pwdata;
        REG_ORIGIN_Y:    cfg.origin_y    <= pwdata;
        REG_TILE_WIDTH:  cfg.tile_width  <= pwdata[30:0];
        REG_TILE_HEIGHT: cfg.tile_height <= pwdata[30:0];
        REG_COLUMNS:     cfg.columns     <= pwdata[6:0];
        REG_ROWS:        cfg.rows        <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X:    prdata = cfg.origin_x;
      REG_ORIGIN_Y:    prdata = cfg.origin_y;
      REG_TILE_WIDTH:  prdata = {1'b0, cfg.tile_width};
      REG_TILE_HEIGHT: prdata = {1'b0, cfg.tile_height};
      REG_COLUMNS:     prdata = {25'd0, cfg.columns};
      REG_ROWS:        prdata = {25'd0, cfg.rows};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== design/tgbc_ctrl.sv =====
`timescale 1ns / 1ps
module tgbc_ctrl
  import tgbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic op,
  input  logic step_more,
  output logic busy,
  output logic done,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_WR_RD   = 3'd1;
  localparam logic [2:0] S_WR_WB   = 3'd2;
  localparam logic [2:0] S_Q_INIT  = 3'd3;
  localparam logic [2:0] S_Q_STEP  = 3'd4;
  localparam logic [2:0] S_Q_DRAIN = 3'd5;
  localparam logic [2:0] S_Q_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.load   = accept;
    case (state)
      S_IDLE: begin
        if (accept) state_next = (op == OP_QUERY) ? S_Q_INIT : S_WR_RD;
      end
      S_WR_RD: begin
        cmd.wr_rd  = 1'b1;
        state_next = S_WR_WB;
      end
      S_WR_WB: begin
        cmd.wr_wb  = 1'b1;
        state_next = S_IDLE;
      end
      S_Q_INIT: begin
        cmd.q_init = 1'b1;
        state_next = S_Q_STEP;
      end
      S_Q_STEP: begin
        cmd.q_step = step_more;
        if (!step_more) state_next = S_Q_DRAIN;
      end
      S_Q_DRAIN: begin
        state_next = S_Q_FIN;
      end
      S_Q_FIN: begin
        cmd.q_fin  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_Q_FIN);
    end
  end

endmodule

// ===== design/tgbc_dp.sv =====
`timescale 1ns / 1ps
module tgbc_dp
  import tgbc_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  input  logic [5:0]         tile_column,
  input  logic [5:0]         tile_row,
  input  logic               tile_solid,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  output logic               step_more,
  output logic               hit
);

  localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // latched item
  logic [5:0]         lat_col;
  logic [5:0]         lat_row;
  logic               lat_solid;
  logic signed [31:0] bx0, by0, bx1, by1;

  // row store, valid bit per row stands in for the reset clear
  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic                   row_valid [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] rdata;
  logic                   rv_q;
  logic [ROW_AW-1:0]      raddr;
  logic [ROW_AW-1:0]      waddr;
  logic [MAX_COLUMNS-1:0] wdata;
  logic                   we;
  logic                   wr_in_range;

  // sweep
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       nc, nr, n_steps;
  logic signed [COORD_W-1:0] tx0, tx1, ty0, ty1;
  logic signed [COORD_W-1:0] tw, th, ox, oy;
  logic signed [COORD_W-1:0] ebx0, eby0, ebx1, eby1;
  logic                   col_ov, row_ov;
  logic                   stage_v, row_en_q, row_ov_q;
  logic [MAX_COLUMNS-1:0] acc;
  logic [MAX_COLUMNS-1:0] colmask;

  assign nc = (9'(cfg.columns) > 9'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : CNT_W'(cfg.columns);
  assign nr = (9'(cfg.rows) > 9'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(cfg.rows);
  assign n_steps   = (nc > nr) ? nc : nr;
  assign step_more = (cnt < n_steps);

  assign ox   = COORD_W'(cfg.origin_x);
  assign oy   = COORD_W'(cfg.origin_y);
  assign tw   = COORD_W'(cfg.tile_width);
  assign th   = COORD_W'(cfg.tile_height);
  assign ebx0 = COORD_W'(bx0);
  assign eby0 = COORD_W'(by0);
  assign ebx1 = COORD_W'(bx1);
  assign eby1 = COORD_W'(by1);

  // strict overlap on each axis for the tile at index cnt
  assign col_ov = (cnt < nc) && (ebx0 < tx1) && (tx0 < ebx1);
  assign row_ov = (eby0 < ty1) && (ty0 < eby1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_col   <= tile_column;
      lat_row   <= tile_row;
      lat_solid <= tile_solid;
      bx0       <= box_min_x;
      by0       <= box_min_y;
      bx1       <= box_max_x;
      by1       <= box_max_y;
    end
  end

  // memory port
  assign raddr = cmd.wr_rd ? ROW_AW'(lat_row) : ROW_AW'(cnt);
  assign waddr = ROW_AW'(lat_row);
  assign wr_in_range = (9'(lat_row) < 9'(MAX_ROWS)) && (9'(lat_col) < 9'(MAX_COLUMNS));
  assign we = cmd.wr_wb && wr_in_range;

  always_comb begin
    wdata = rv_q ? rdata : '0;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      if (9'(lat_col) == 9'(i)) wdata[i] = lat_solid;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
    rv_q  <= row_valid[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ROWS; i++) row_valid[i] <= 1'b0;
    end else if (we) begin
      row_valid[waddr] <= 1'b1;
    end
  end

  // sweep: row k and column k tested in the same step
  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      cnt     <= '0;
      tx0     <= ox;
      tx1     <= ox + tw;
      ty0     <= oy;
      ty1     <= oy + th;
      colmask <= '0;
    end else if (cmd.q_step) begin
      cnt <= cnt + 1'b1;
      tx0 <= tx1;
      tx1 <= tx1 + tw;
      ty0 <= ty1;
      ty1 <= ty1 + th;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        if (cnt == CNT_W'(i)) colmask[i] <= col_ov;
      end
    end
    row_en_q <= (cnt < nr);
    row_ov_q <= row_ov;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
    end else begin
      stage_v <= cmd.q_step;
    end
  end

  // OR of overlapping solid rows, masked by overlapping columns at the end
  always_ff @(posedge clk) begin
    if (cmd.q_init) begin
      acc <= '0;
    end else if (stage_v && row_en_q && row_ov_q && rv_q) begin
      acc <= acc | rdata;
    end
    if (cmd.q_fin) hit <= |(acc & colmask);
  end

endmodule

// ===== design/tile_grid_box_collision.sv =====
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// item in   start, busy             op, tile_column, tile_row, tile_solid, box_min/max_x/y
// result    done (one-cycle strobe) hit
// config    APB psel/penable/pwrite origin_x, origin_y, tile_width, tile_height, columns,
//                                   rows at paddr 0x00..0x14
//
// Tile write: busy for the row word read, then modify and write back; the next
// transfer is taken once busy drops; no result. Query: busy for init, a sweep
// of N = max(columns, rows) steps after saturation that reads one row word per
// cycle, a drain and the reduce; done shows for one cycle right after, while
// busy is already low, and hit is registered with done and holds until the next query.
// Reset (rst, synchronous): all rows marked empty at once through per-row valid
// bits, registers to their defaults. The receiver cannot stall; no backpressure.
module tile_grid_box_collision
  import tgbc_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  // item in
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [5:0]         tile_column,
  input  logic [5:0]         tile_row,
  input  logic               tile_solid,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  // result
  output logic               done,
  output logic               hit,
  // config
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  logic step_more;

  // register file, to be written only while idle; the block itself does not enforce it
  tgbc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: write read-modify-write and query sweep
  tgbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .step_more (step_more),
    .busy      (busy),
    .done      (done),
    .cmd       (cmd)
  );

  // tile store, bound generators and overlap compares
  tgbc_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .tile_column (tile_column),
    .tile_row    (tile_row),
    .tile_solid  (tile_solid),
    .box_min_x   (box_min_x),
    .box_min_y   (box_min_y),
    .box_max_x   (box_max_x),
    .box_max_y   (box_max_y),
    .step_more   (step_more),
    .hit         (hit)
  );

endmodule

// ===== tb/sv/tgbc_hit_checker.sv =====
`timescale 1ns / 1ps
module tgbc_hit_checker
  import tgbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               op,
  input  logic [5:0]         tile_column,
  input  logic [5:0]         tile_row,
  input  logic               tile_solid,
  input  logic signed [31:0] box_min_x,
  input  logic signed [31:0] box_min_y,
  input  logic signed [31:0] box_max_x,
  input  logic signed [31:0] box_max_y,
  input  logic               done,
  input  logic               hit,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  output int                 fail_cnt,
  output int                 hits_owed
);

  localparam int NCOL = DEF_MAX_COLUMNS;
  localparam int NROW = DEF_MAX_ROWS;

  cfg_t cfg;
  bit   solid_map [NROW][NCOL];
  bit   pending_hits [$];

  // strict overlap on both axes, bounds in 64 bit so nothing wraps
  function automatic bit solid_overlap(input logic signed [31:0] bx0, by0, bx1, by1);
    int     nc, nr;
    longint ox, oy, tw, th;
    longint tx0, tx1, ty0, ty1;
    nc = (cfg.columns > NCOL) ? NCOL : int'(cfg.columns);
    nr = (cfg.rows > NROW) ? NROW : int'(cfg.rows);
    ox = $signed(cfg.origin_x);
    oy = $signed(cfg.origin_y);
    tw = cfg.tile_width;
    th = cfg.tile_height;
    for (int r = 0; r < nr; r++) begin
      ty0 = oy + r * th;
      ty1 = ty0 + th;
      if (longint'(by0) < ty1 && ty0 < longint'(by1)) begin
        for (int c = 0; c < nc; c++) begin
          tx0 = ox + c * tw;
          tx1 = tx0 + tw;
          if (solid_map[r][c] && longint'(bx0) < tx1 && tx0 < longint'(bx1))
            return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : track
    bit want;
    if (rst) begin
      cfg.origin_x    = '0;
      cfg.origin_y    = '0;
      cfg.tile_width  = 31'd65536;
      cfg.tile_height = 31'd65536;
      cfg.columns     = 7'd64;
      cfg.rows        = 7'd64;
      foreach (solid_map[r, c]) solid_map[r][c] = 1'b0;
      pending_hits.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ORIGIN_X:    cfg.origin_x    = pwdata;
          REG_ORIGIN_Y:    cfg.origin_y    = pwdata;
          REG_TILE_WIDTH:  cfg.tile_width  = pwdata[30:0];
          REG_TILE_HEIGHT: cfg.tile_height = pwdata[30:0];
          REG_COLUMNS:     cfg.columns     = pwdata[6:0];
          REG_ROWS:        cfg.rows        = pwdata[6:0];
          default: ;
        endcase
      end
      if (done) begin
        if (pending_hits.size() == 0) begin
          $error("hit: no result expected, actual %0d", hit);
          fail_cnt++;
        end else begin
          want = pending_hits.pop_front();
          if (hit !== want) begin
            $error("hit: expected %0d, actual %0d", want, hit);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        if (op == OP_WRITE)
          solid_map[tile_row][tile_column] = tile_solid;
        else
          pending_hits.push_back(solid_overlap(box_min_x, box_min_y, box_max_x, box_max_y));
      end
    end
    hits_owed = pending_hits.size();
  end

endmodule

// ===== tb/sv/tile_grid_box_collision_tb.sv =====
`timescale 1ns / 1ps
module tile_grid_box_collision_tb;
  import tgbc_pkg::*;

  // Run bound: ~1400 items plus config phases and drains; the limit leaves a wide margin.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 225;

  localparam logic signed [31:0] ONE  = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CMIN = 32'sh8000_0000;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               busy;
  logic               op          = OP_WRITE;
  logic [5:0]         tile_column = '0;
  logic [5:0]         tile_row    = '0;
  logic               tile_solid  = 1'b0;
  logic signed [31:0] box_min_x   = '0;
  logic signed [31:0] box_min_y   = '0;
  logic signed [31:0] box_max_x   = '0;
  logic signed [31:0] box_max_y   = '0;
  logic               done;
  logic               hit;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [ADDR_W-1:0]  paddr       = '0;
  logic [DATA_W-1:0]  pwdata      = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int fail_cnt;
  int hits_owed;
  int cycles   = 0;
  bit idle_on  = 1'b1;

  // Grid geometry as the stimulus sees it, used only to aim boxes at tile
  // edges and tile writes at the tiles in use.
  longint org_x     = 0;
  longint org_y     = 0;
  longint step_x    = 65536;
  longint step_y    = 65536;
  int     cols_used = 64;
  int     rows_used = 64;

  always #2 clk = ~clk;

  tile_grid_box_collision u_dut (.*);

  tgbc_hit_checker u_chk (.*);

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL tile_grid_box_collision");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle; pready is tied high so the
  // register takes the value at the edge that ends the access cycle.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Sender holds off until every query result is back and the block is idle.
  // A tile write leaves no result behind, so the wait on busy covers its
  // read-modify-write before any register changes.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (hits_owed != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_grid(input logic signed [31:0] ox, oy, input logic [31:0] tw, th,
                          input logic [6:0] nc, nr);
    drain();
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_TILE_WIDTH, tw);
    cfg_write(REG_TILE_HEIGHT, th);
    cfg_write(REG_COLUMNS, {25'd0, nc});
    cfg_write(REG_ROWS, {25'd0, nr});
    org_x     = ox;
    org_y     = oy;
    step_x    = tw[30:0];
    step_y    = th[30:0];
    cols_used = (nc > 64) ? 64 : int'(nc);
    rows_used = (nr > 64) ? 64 : int'(nr);
  endtask

  // One item transfer. start stays high from one item to the next unless an
  // idle burst is drawn; half the bursts first wait for the block to go idle
  // so gaps land both inside and after the block's work.
  task automatic send(input logic o, input logic [5:0] c, r, input logic s,
                      input logic signed [31:0] x0, y0, x1, y1);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      if ($urandom_range(0, 1)) while (busy) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    start       = 1'b1;
    op          = o;
    tile_column = c;
    tile_row    = r;
    tile_solid  = s;
    box_min_x   = x0;
    box_min_y   = y0;
    box_max_x   = x1;
    box_max_y   = y1;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // Coordinate near a tile edge of one axis: mostly origin + k*stride with a
  // tiny nudge or a fraction of a tile, sometimes fully random or an extreme.
  function automatic logic signed [31:0] edge_coord(input longint org, input longint stride,
                                                    input int n);
    longint v;
    int     k;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? CMAX : CMIN;
      default: begin
        k = int'($urandom_range(0, n + 2)) - 1;
        v = org + k * stride;
        if ($urandom_range(0, 1))
          v = v + (int'($urandom_range(0, 4)) - 2);
        else
          v = v + longint'($urandom_range(0, stride));
      end
    endcase
    if (v > 64'sd2147483647)
      v = 64'sd2147483647;
    else if (v < -64'sd2147483648)
      v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic rand_item(input int solid_pct);
    logic               o, s;
    logic [5:0]         c, r;
    logic signed [31:0] x0, y0, x1, y1, t;
    o  = ($urandom_range(0, 99) < 55) ? OP_QUERY : OP_WRITE;
    // mostly tiles in use; now and then anywhere in the store
    c  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                     : 6'($urandom_range(0, cols_used == 0 ? 63 : cols_used - 1));
    r  = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                     : 6'($urandom_range(0, rows_used == 0 ? 63 : rows_used - 1));
    s  = ($urandom_range(0, 99) < solid_pct);
    x0 = edge_coord(org_x, step_x, cols_used);
    x1 = edge_coord(org_x, step_x, cols_used);
    y0 = edge_coord(org_y, step_y, rows_used);
    y1 = edge_coord(org_y, step_y, rows_used);
    // keep most boxes ordered, leave some inverted
    if ($urandom_range(0, 9) != 0) begin
      if (x0 > x1) begin
        t  = x0;
        x0 = x1;
        x1 = t;
      end
      if (y0 > y1) begin
        t  = y0;
        y0 = y1;
        y1 = t;
      end
    end
    send(o, c, r, s, x0, y0, x1, y1);
  endtask

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return CMIN;
      2: return CMAX;
      3: return $urandom();
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  // bit 31 of a stride write is random at times; only 31 bits are kept
  function automatic logic [31:0] pick_stride();
    case ($urandom_range(0, 7))
      0: return 32'h0001_0000;
      1: return 32'h1;
      2: return 32'h7FFF_FFFF;
      3: return $urandom();
      4: return 32'h0;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  function automatic logic [6:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 7'd1;
      1: return 7'd64;
      2: return 7'($urandom_range(65, 127));
      3: return 7'd0;
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    // reset held at the start, then released for good
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // ---- directed: default grid, 64x64 tiles of 1.0 at the origin ----
    send(OP_QUERY, 6'd63, 6'd63, 1'b1, CMIN, CMIN, CMAX, CMAX);      // empty store
    send(OP_WRITE, 6'd0, 6'd0, 1'b1, CMAX, CMAX, CMIN, CMIN);
    send(OP_WRITE, 6'd63, 6'd63, 1'b1, '0, '0, '0, '0);
    send(OP_WRITE, 6'd20, 6'd30, 1'b1, '0, '0, '0, '0);
    send(OP_WRITE, 6'd20, 6'd30, 1'b0, '0, '0, '0, '0);             // cleared again
    send(OP_QUERY, '0, '0, 1'b0, '0, '0, ONE, ONE);                  // covers tile (0,0)
    send(OP_QUERY, '0, '0, 1'b0, ONE, '0, 2 * ONE, ONE);             // only touches its edge
    send(OP_QUERY, '0, '0, 1'b0, CMIN, CMIN, CMAX, CMAX);
    send(OP_QUERY, '0, '0, 1'b0, CMAX, CMAX, CMIN, CMIN);            // inverted box
    send(OP_QUERY, '0, '0, 1'b0, 63 * ONE + 1, 63 * ONE + 1, CMAX, CMAX);
    send(OP_WRITE, 6'd5, 6'd40, 1'b1, '0, '0, '0, '0);

    // no columns in use: nothing can hit
    set_grid('0, '0, ONE, ONE, 7'd0, 7'd64);
    send(OP_QUERY, '0, '0, 1'b0, CMIN, CMIN, CMAX, CMAX);
    // counts above the store size saturate
    set_grid('0, '0, ONE, ONE, 7'd127, 7'd100);
    send(OP_QUERY, '0, '0, 1'b0, CMIN, CMIN, CMAX, CMAX);
    // zero stride, origin at the corners of the number range
    set_grid(CMIN, CMAX, 32'h0, 32'h0, 7'd4, 7'd64);
    send(OP_QUERY, '0, '0, 1'b0, CMIN, CMIN, CMAX, CMAX);
    // zero-extent tile strictly inside the box, then on its edge
    set_grid(-ONE, -ONE, 32'h0, 32'h0, 7'd1, 7'd1);
    send(OP_QUERY, '0, '0, 1'b0, -2 * ONE, -2 * ONE, '0, '0);
    send(OP_QUERY, '0, '0, 1'b0, -ONE, -ONE, '0, '0);
    // widest stride (bit 31 of the write dropped), grid starting at the top
    set_grid(CMAX, CMIN, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 7'd64, 7'd64);
    send(OP_QUERY, '0, '0, 1'b0, CMIN, CMIN, CMAX, CMAX);
    // widest stride from the bottom: tile bounds far beyond 32 bits
    set_grid(CMIN, CMIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd64, 7'd2);
    send(OP_QUERY, '0, '0, 1'b0, CMIN, CMIN, CMAX, CMAX);

    // ---- random phases, each with a fresh grid setting ----
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0)
        set_grid('0, '0, ONE, ONE, 7'd8, 7'd8);   // small dense grid, hits common
      else
        set_grid(pick_origin(), pick_origin(), pick_stride(), pick_stride(),
                 pick_count(), pick_count());
      idle_on = (p != RAND_PHASES - 1);           // last phase runs back to back
      begin : phase_run
        int solid_pct;
        solid_pct = $urandom_range(10, 90);
        for (int i = 0; i < PHASE_ITEMS; i++) rand_item(solid_pct);
      end
    end

    // all stimulus in; wait for every result, then past the longest query
    drain();
    repeat (72) @(negedge clk);
    if (fail_cnt == 0)
      $display("PASS tile_grid_box_collision");
    else
      $display("FAIL tile_grid_box_collision");
    $finish;
  end

endmodule
